@@ sv/beacon_source_table_top_defines.svh @@
// Assertion macros for the beacon source table RTL.
`ifndef BEACON_SOURCE_TABLE_TOP_DEFINES_SVH
`define BEACON_SOURCE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define BST_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define BST_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bst_pkg.sv @@
// Types and constants of the beacon source table.
package bst_pkg;

    localparam logic [31:0] BCAST_HEAD = 32'hffff_ffff;

    localparam logic [2:0] STATUS_NOT_MGMT   = 3'd0;
    localparam logic [2:0] STATUS_NOT_BCAST  = 3'd1;
    localparam logic [2:0] STATUS_EMPTY_SSID = 3'd2;
    localparam logic [2:0] STATUS_INSERTED   = 3'd3;
    localparam logic [2:0] STATUS_UPDATED    = 3'd4;
    localparam logic [2:0] STATUS_FULL       = 3'd5;

    localparam logic [1:0] FTYPE_MGMT = 2'd0;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  entry_index;
        logic [5:0]  entry_count;
        logic [31:0] source_id;
        logic [7:0]  stored_channel;
    } result_t;

    // Source id: MAC bytes 0..3 little endian plus bytes 4 and 5, mod 2^32.
    function automatic logic [31:0] source_key(input logic [47:0] mac);
        return mac[31:0] + {24'd0, mac[39:32]} + {24'd0, mac[47:40]};
    endfunction

endpackage

@@ sv/beacon_source_table_top.sv @@
// Beacon source table: top level with the key memory, sequencer and result register.
//
//  channel | ports      | handshake       | word
//  --------+------------+-----------------+-------------------------------------
//  input   | s_*        | s_valid/s_ready | one captured frame header
//  result  | m_*        | m_valid/m_ready | status, index, count, id, channel
//
// A word rejected before lookup skips the key scan; with an empty table no slot is read.
// Otherwise the key scan reads one memory slot per cycle, compares each key once its
// registered read data returns, and stops at the first match.
// aresetn is synchronous, active low; it empties the table (count to zero).
// A finished result waits in the output register; the next word is taken meanwhile,
// and the sequencer holds its own result until that register is free.
module beacon_source_table_top #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_frame_type,
    input  logic [31:0] s_addr1_head,
    input  logic [31:0] s_addr3_head,
    input  logic [47:0] s_source_mac,
    input  logic [63:0] s_ssid_word0,
    input  logic [63:0] s_ssid_word1,
    input  logic [63:0] s_ssid_word2,
    input  logic [63:0] s_ssid_word3,
    input  logic signed [7:0] s_rssi,
    input  logic [7:0]  s_frame_channel,
    input  logic [7:0]  s_tuned_channel,
    input  logic [31:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [4:0]  m_entry_index,
    output logic [5:0]  m_entry_count,
    output logic [31:0] m_source_id,
    output logic [7:0]  m_stored_channel
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // rssi, time, MAC and SSID body have no readout port and are not retained;
    // only the SSID head decides on insertion.

    logic              out_free;
    logic              res_valid;
    bst_pkg::result_t  res;
    logic              m_valid_reg, m_valid_next;
    bst_pkg::result_t  out_reg;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [31:0]       ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [31:0]       ram_rd_data;

    bst_key_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bst_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CW          (CW),
        .AW          (AW)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_valid),
        .in_ready         (s_ready),
        .frame_type       (s_frame_type),
        .addr1_head       (s_addr1_head),
        .addr3_head       (s_addr3_head),
        .source_mac       (s_source_mac),
        .ssid_head        (s_ssid_word0[15:0]),
        .frame_channel    (s_frame_channel),
        .tuned_channel    (s_tuned_channel),
        .out_free         (out_free),
        .res_valid        (res_valid),
        .res              (res),
        .ram_wr_en        (ram_wr_en),
        .ram_wr_addr      (ram_wr_addr),
        .ram_wr_data      (ram_wr_data),
        .ram_rd_en        (ram_rd_en),
        .ram_rd_addr      (ram_rd_addr),
        .ram_rd_data      (ram_rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_reg.status;
    assign m_entry_index    = out_reg.entry_index;
    assign m_entry_count    = out_reg.entry_count;
    assign m_source_id      = out_reg.source_id;
    assign m_stored_channel = out_reg.stored_channel;

endmodule

@@ sv/bst_key_ram.sv @@
// Key memory: one write port, one read port with registered data.
module bst_key_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/bst_seq.sv @@
// Sequencer: frame classification, key scan over the memory, insert and update.
`include "beacon_source_table_top_defines.svh"

module bst_seq #(
    parameter int MAX_ENTRIES = 32,
    parameter int CW          = 6,
    parameter int AW          = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        frame_type,
    input  logic [31:0]       addr1_head,
    input  logic [31:0]       addr3_head,
    input  logic [47:0]       source_mac,
    input  logic [15:0]       ssid_head,
    input  logic [7:0]        frame_channel,
    input  logic [7:0]        tuned_channel,
    input  logic              out_free,
    output logic              res_valid,
    output bst_pkg::result_t  res,
    output logic              ram_wr_en,
    output logic [AW-1:0]     ram_wr_addr,
    output logic [31:0]       ram_wr_data,
    output logic              ram_rd_en,
    output logic [AW-1:0]     ram_rd_addr,
    input  logic [31:0]       ram_rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     scan_addr_reg, scan_addr_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [31:0]       id_reg, id_next;
    logic [7:0]        chan_reg, chan_next;
    logic              ssid_ok_reg, ssid_ok_next;
    bst_pkg::result_t  res_reg, res_next;

    logic              accept;
    logic              hit;
    logic              issue;
    logic [31:0]       in_id;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_id     = bst_pkg::source_key(source_mac);
    assign hit       = cmp_valid_reg && (ram_rd_data == id_reg);
    assign issue     = (state_reg == ST_SCAN) && !hit && (scan_addr_reg < count_reg);

    assign ram_rd_en   = issue;
    assign ram_rd_addr = scan_addr_reg[AW-1:0];
    assign ram_wr_addr = count_reg[AW-1:0];
    assign ram_wr_data = id_reg;

    assign res_valid = (state_reg == ST_DONE) && out_free;
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_addr_next = scan_addr_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        id_next        = id_reg;
        chan_next      = chan_reg;
        ssid_ok_next   = ssid_ok_reg;
        res_next       = res_reg;
        ram_wr_en      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    id_next        = in_id;
                    chan_next      = (frame_channel != 8'd0) ? frame_channel : tuned_channel;
                    ssid_ok_next   = (ssid_head != 16'd0);
                    scan_addr_next = '0;
                    res_next.source_id      = in_id;
                    res_next.entry_index    = 5'd0;
                    res_next.entry_count    = 6'(count_reg);
                    res_next.stored_channel = 8'd0;
                    if (frame_type != bst_pkg::FTYPE_MGMT) begin
                        res_next.status = bst_pkg::STATUS_NOT_MGMT;
                        state_next      = ST_DONE;
                    end else if (addr1_head != bst_pkg::BCAST_HEAD ||
                                 addr3_head != bst_pkg::BCAST_HEAD) begin
                        res_next.status = bst_pkg::STATUS_NOT_BCAST;
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // the read data of slot n is registered before its key is compared
                if (issue) begin
                    scan_addr_next = scan_addr_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_addr_reg[AW-1:0];
                end
                if (hit) begin
                    res_next.status         = bst_pkg::STATUS_UPDATED;
                    res_next.entry_index    = 5'(cmp_idx_reg);
                    res_next.stored_channel = chan_reg;
                    state_next              = ST_DONE;
                end else if (!cmp_valid_reg && !issue) begin
                    state_next = ST_DONE;
                    if (!ssid_ok_reg) begin
                        res_next.status = bst_pkg::STATUS_EMPTY_SSID;
                    end else if (count_reg == CW'(MAX_ENTRIES)) begin
                        res_next.status = bst_pkg::STATUS_FULL;
                    end else begin
                        ram_wr_en            = 1'b1;
                        count_next           = count_reg + CW'(1);
                        res_next.status      = bst_pkg::STATUS_INSERTED;
                        res_next.entry_index = 5'(count_reg);
                        res_next.entry_count = 6'(count_reg + CW'(1));
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_addr_reg <= scan_addr_next;
        cmp_idx_reg   <= cmp_idx_next;
        id_reg        <= id_next;
        chan_reg      <= chan_next;
        ssid_ok_reg   <= ssid_ok_next;
        res_reg       <= res_next;
    end

    `BST_CHECK(a_count_bound, 1'b1, count_reg <= CW'(MAX_ENTRIES), "entry count above table size")
    `BST_CHECK(a_write_room, ram_wr_en, (state_reg == ST_SCAN) && (count_reg < CW'(MAX_ENTRIES)), "key write with no free slot")
    `BST_CHECK_NEXT(a_write_count, ram_wr_en, count_reg == $past(count_reg) + CW'(1), "insert did not advance count")
    `BST_CHECK(a_read_in_range, ram_rd_en, scan_addr_reg < count_reg, "read of unwritten slot")

endmodule

@@ dv/beacon_table_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the beacon source table: predicts each result word and compares it.
module beacon_table_checker #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_frame_type,
    input  logic [31:0] s_addr1_head,
    input  logic [31:0] s_addr3_head,
    input  logic [47:0] s_source_mac,
    input  logic [63:0] s_ssid_word0,
    input  logic [7:0]  s_frame_channel,
    input  logic [7:0]  s_tuned_channel,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [4:0]  m_entry_index,
    input  logic [5:0]  m_entry_count,
    input  logic [31:0] m_source_id,
    input  logic [7:0]  m_stored_channel,
    output int          mismatch_count,
    output int          outstanding
);

    // keys of the stored sources; only slots below stored_sources are ever read
    logic [31:0]      key_tbl [MAX_ENTRIES];
    int               stored_sources = 0;
    int               errors = 0;
    bst_pkg::result_t table_results [$];

    function automatic bst_pkg::result_t predict_table_step(
        input logic [1:0]  ftype,
        input logic [31:0] a1,
        input logic [31:0] a3,
        input logic [47:0] mac,
        input logic [15:0] ssid_head,
        input logic [7:0]  fch,
        input logic [7:0]  ech
    );
        bst_pkg::result_t r;
        logic [31:0]      id;
        int               hit;
        id = mac[31:0] + 32'(mac[39:32]) + 32'(mac[47:40]);
        r = '0;
        r.source_id = id;
        hit = -1;
        if (ftype != bst_pkg::FTYPE_MGMT) begin
            r.status = bst_pkg::STATUS_NOT_MGMT;
        end else if (a1 != bst_pkg::BCAST_HEAD || a3 != bst_pkg::BCAST_HEAD) begin
            r.status = bst_pkg::STATUS_NOT_BCAST;
        end else begin
            for (int i = 0; i < stored_sources; i++) begin
                if (hit < 0 && key_tbl[i] == id) hit = i;
            end
            if (hit >= 0) begin
                r.status = bst_pkg::STATUS_UPDATED;
                r.entry_index = 5'(hit);
                r.stored_channel = (fch != 8'd0) ? fch : ech;
            end else if (ssid_head == 16'd0) begin
                // empty ssid wins over a full table
                r.status = bst_pkg::STATUS_EMPTY_SSID;
            end else if (stored_sources >= MAX_ENTRIES) begin
                r.status = bst_pkg::STATUS_FULL;
            end else begin
                key_tbl[stored_sources] = id;
                r.status = bst_pkg::STATUS_INSERTED;
                r.entry_index = 5'(stored_sources);
                stored_sources++;
            end
        end
        r.entry_count = 6'(stored_sources);
        return r;
    endfunction

    always @(posedge aclk) begin
        bst_pkg::result_t want;
        bst_pkg::result_t got;
        if (aresetn) begin
            // compare before predicting: a word taken at this edge cannot finish here
            if (m_valid && m_ready) begin
                got.status = m_status;
                got.entry_index = m_entry_index;
                got.entry_count = m_entry_count;
                got.source_id = m_source_id;
                got.stored_channel = m_stored_channel;
                if (table_results.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: result word with nothing outstanding: st=%0d idx=%0d cnt=%0d id=%h ch=%0d",
                                 $time, got.status, got.entry_index, got.entry_count,
                                 got.source_id, got.stored_channel);
                    errors++;
                end else begin
                    want = table_results.pop_front();
                    if (got.status !== want.status || got.entry_index !== want.entry_index ||
                        got.entry_count !== want.entry_count ||
                        got.source_id !== want.source_id ||
                        got.stored_channel !== want.stored_channel) begin
                        if (errors < 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  status   exp %0d got %0d", want.status, got.status);
                            $display("  index    exp %0d got %0d", want.entry_index,
                                     got.entry_index);
                            $display("  count    exp %0d got %0d", want.entry_count,
                                     got.entry_count);
                            $display("  id       exp %h got %h", want.source_id, got.source_id);
                            $display("  channel  exp %0d got %0d", want.stored_channel,
                                     got.stored_channel);
                        end
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                table_results.push_back(predict_table_step(s_frame_type, s_addr1_head,
                    s_addr3_head, s_source_mac, s_ssid_word0[15:0], s_frame_channel,
                    s_tuned_channel));
        end
        mismatch_count <= errors;
        outstanding <= table_results.size();
    end

endmodule

@@ dv/beacon_source_table_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the beacon source table: frame stimulus, receiver stalls and verdict.
module beacon_source_table_top_tb;

    localparam int ITEM_COUNT   = 550;
    localparam int POOL_SIZE    = 40;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [1:0]  frame_type;
        logic [31:0] addr1_head;
        logic [31:0] addr3_head;
        logic [47:0] source_mac;
        logic [63:0] ssid_word0;
        logic [63:0] ssid_word1;
        logic [63:0] ssid_word2;
        logic [63:0] ssid_word3;
        logic [7:0]  rssi;
        logic [7:0]  frame_channel;
        logic [7:0]  tuned_channel;
        logic [31:0] now_time;
    } frame_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PULSED} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic [1:0]  s_frame_type = '0;
    logic [31:0] s_addr1_head = '0;
    logic [31:0] s_addr3_head = '0;
    logic [47:0] s_source_mac = '0;
    logic [63:0] s_ssid_word0 = '0;
    logic [63:0] s_ssid_word1 = '0;
    logic [63:0] s_ssid_word2 = '0;
    logic [63:0] s_ssid_word3 = '0;
    logic signed [7:0] s_rssi = '0;
    logic [7:0]  s_frame_channel = '0;
    logic [7:0]  s_tuned_channel = '0;
    logic [31:0] s_now_time = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_status;
    logic [4:0]  m_entry_index;
    logic [5:0]  m_entry_count;
    logic [31:0] m_source_id;
    logic [7:0]  m_stored_channel;

    int          mismatches;
    int          outstanding;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          sending = 1'b0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic [47:0] mac_pool [POOL_SIZE];

    always #6 aclk = ~aclk;

    beacon_source_table_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_frame_type(s_frame_type), .s_addr1_head(s_addr1_head),
        .s_addr3_head(s_addr3_head), .s_source_mac(s_source_mac),
        .s_ssid_word0(s_ssid_word0), .s_ssid_word1(s_ssid_word1),
        .s_ssid_word2(s_ssid_word2), .s_ssid_word3(s_ssid_word3),
        .s_rssi(s_rssi), .s_frame_channel(s_frame_channel),
        .s_tuned_channel(s_tuned_channel), .s_now_time(s_now_time),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_entry_index(m_entry_index),
        .m_entry_count(m_entry_count), .m_source_id(m_source_id),
        .m_stored_channel(m_stored_channel)
    );

    beacon_table_checker table_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_frame_type(s_frame_type), .s_addr1_head(s_addr1_head),
        .s_addr3_head(s_addr3_head), .s_source_mac(s_source_mac),
        .s_ssid_word0(s_ssid_word0), .s_frame_channel(s_frame_channel),
        .s_tuned_channel(s_tuned_channel),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_entry_index(m_entry_index),
        .m_entry_count(m_entry_count), .m_source_id(m_source_id),
        .m_stored_channel(m_stored_channel),
        .mismatch_count(mismatches), .outstanding(outstanding)
    );

    // receiver: open, random, or a pulsed ready, each held for a random stretch
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(2));
            rx_left <= $urandom_range(1, 60);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= 1'($urandom_range(1));
            default:   m_ready <= (rx_left % 5 == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("beacon_source_table_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // well-formed broadcast beacon with random content and a non-empty ssid
    function automatic frame_t bcast_frame(input logic [47:0] mac);
        frame_t f;
        f.frame_type = bst_pkg::FTYPE_MGMT;
        f.addr1_head = bst_pkg::BCAST_HEAD;
        f.addr3_head = bst_pkg::BCAST_HEAD;
        f.source_mac = mac;
        f.ssid_word0 = {$urandom, $urandom};
        f.ssid_word1 = {$urandom, $urandom};
        f.ssid_word2 = {$urandom, $urandom};
        f.ssid_word3 = {$urandom, $urandom};
        if (f.ssid_word0[15:0] == 16'd0) f.ssid_word0[0] = 1'b1;
        f.rssi = 8'($urandom);
        f.frame_channel = 8'($urandom);
        f.tuned_channel = 8'($urandom);
        f.now_time = $urandom;
        return f;
    endfunction

    function automatic logic [47:0] random_mac();
        return {16'($urandom), $urandom};
    endfunction

    // present one word, hold it until taken, then maybe end the burst
    task automatic drive_frame(input frame_t f);
        s_valid <= 1'b1;
        sending = 1'b1;
        s_frame_type <= f.frame_type;
        s_addr1_head <= f.addr1_head;
        s_addr3_head <= f.addr3_head;
        s_source_mac <= f.source_mac;
        s_ssid_word0 <= f.ssid_word0;
        s_ssid_word1 <= f.ssid_word1;
        s_ssid_word2 <= f.ssid_word2;
        s_ssid_word3 <= f.ssid_word3;
        s_rssi <= f.rssi;
        s_frame_channel <= f.frame_channel;
        s_tuned_channel <= f.tuned_channel;
        s_now_time <= f.now_time;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            sending = 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
        end
    endtask

    initial begin
        frame_t      f;
        int          sel;
        logic [47:0] mac;

        for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = random_mac();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // not management, every nonzero type
        f = bcast_frame(48'h1234_5678_9abc);
        for (int t = 1; t < 4; t++) begin
            f.frame_type = 2'(t);
            drive_frame(f);
        end
        // not broadcast: address 1, address 3, both
        f = bcast_frame(48'h1234_5678_9abc);
        f.addr1_head = 32'hffff_fffe;
        drive_frame(f);
        f = bcast_frame(48'h1234_5678_9abc);
        f.addr3_head = 32'h7fff_ffff;
        drive_frame(f);
        f = bcast_frame(48'h1234_5678_9abc);
        f.addr1_head = '0;
        f.addr3_head = '0;
        drive_frame(f);
        // unknown source with empty ssid, upper ssid bytes set
        f = bcast_frame(48'h0a0b_0c0d_0e0f);
        f.ssid_word0 = 64'hffff_ffff_ffff_0000;
        drive_frame(f);
        // all-ones mac: key wraps; ssid byte 0 zero but byte 1 set still counts
        f = bcast_frame('1);
        f.ssid_word0[15:0] = 16'h4100;
        drive_frame(f);
        // known source ignores an empty ssid; zero frame channel takes the tuned one
        f = bcast_frame('1);
        f.ssid_word0 = '0;
        f.frame_channel = 8'd0;
        f.tuned_channel = 8'hff;
        drive_frame(f);
        f = bcast_frame('1);
        f.frame_channel = 8'd1;
        f.tuned_channel = 8'd0;
        drive_frame(f);
        // zero mac, ssid with only byte 0 set
        f = bcast_frame('0);
        f.ssid_word0 = 64'h53;
        drive_frame(f);
        f = bcast_frame('0);
        f.frame_channel = 8'hff;
        f.rssi = 8'h80;
        f.now_time = '0;
        drive_frame(f);
        f = bcast_frame('0);
        f.frame_channel = 8'd0;
        f.tuned_channel = 8'd0;
        f.rssi = 8'h7f;
        f.now_time = '1;
        drive_frame(f);
        // two macs with the same key: the second one updates the first entry
        f = bcast_frame(48'h0102_0000_0010);
        drive_frame(f);
        f = bcast_frame(48'h0000_0000_0013);
        drive_frame(f);
        f = bcast_frame(48'h0102_0000_0010);
        f.frame_type = 2'd3;
        drive_frame(f);
        // unknown source, all ssid words zero
        f = bcast_frame(48'h8000_0000_0001);
        f.ssid_word0 = '0;
        f.ssid_word1 = '0;
        f.ssid_word2 = '0;
        f.ssid_word3 = '0;
        drive_frame(f);

        // mostly well-formed beacons from a recurring pool, so the table fills and overflows
        for (int n = 0; n < ITEM_COUNT; n++) begin
            sel = $urandom_range(99);
            mac = ($urandom_range(4) == 0) ? random_mac() : mac_pool[$urandom_range(POOL_SIZE - 1)];
            f = bcast_frame(mac);
            if (sel < 10) begin
                f.frame_type = 2'($urandom_range(1, 3));
                if ($urandom_range(1) == 1) begin
                    f.addr1_head = $urandom;
                    f.addr3_head = $urandom;
                end
            end else if (sel < 20) begin
                case ($urandom_range(2))
                    0: f.addr1_head = $urandom;
                    1: f.addr3_head = $urandom;
                    default: begin
                        f.addr1_head = $urandom;
                        f.addr3_head = $urandom;
                    end
                endcase
            end else begin
                if ($urandom_range(9) == 0)
                    f.ssid_word0[15:0] = 16'd0;
                else if ($urandom_range(9) == 0)
                    f.ssid_word0[7:0] = 8'd0;
                if ($urandom_range(3) == 0) f.frame_channel = 8'd0;
            end
            drive_frame(f);
        end
        if (sending) s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("beacon_source_table_top verification clean");
        end else begin
            $display("beacon_source_table_top verification failed");
        end
        $finish;
    end

endmodule
